/* hdl/lru_page_cache_byte_valid_top_assert.svh */
// Assertion macros used by the checker of the page cache.
`ifndef LRU_PAGE_CACHE_BYTE_VALID_TOP_ASSERT_SVH
`define LRU_PAGE_CACHE_BYTE_VALID_TOP_ASSERT_SVH

// Checks that an expression holds at every clock edge outside reset.
`define LPCBV_ASSERT(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a condition at one edge is followed by another at the next edge.
`define LPCBV_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lpcbv_pkg.sv */
// Shared types and constants of the page cache.
package lpcbv_pkg;

	localparam int LANES     = 8;
	localparam int DATA_W    = 64;
	localparam int IN_W      = 136;
	localparam int OUT_W     = 72;
	localparam int CNT_OUT_W = 5;
	localparam int LANE_W    = 9;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_FILL   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic REG_ENABLE = 1'b0;
	localparam logic REG_MAX    = 1'b1;

	localparam logic       ENABLE_RST    = 1'b1;
	localparam logic [4:0] MAX_PAGES_RST = 5'd16;

	typedef struct packed {
		logic capture;
		logic match;
		logic clear_all;
		logic touch;
		logic alloc;
		logic check;
		logic sweep_init;
		logic sweep_page;
		logic write;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       go;
		logic       found;
		logic       sweep_last;
	} dp_stat_t;

	typedef enum logic [7:0] {
		ST_INIT   = 8'b0000_0001,
		ST_IDLE   = 8'b0000_0010,
		ST_MATCH  = 8'b0000_0100,
		ST_DECIDE = 8'b0000_1000,
		ST_CHECK  = 8'b0001_0000,
		ST_SWEEP  = 8'b0010_0000,
		ST_WRITE  = 8'b0100_0000,
		ST_RESP   = 8'b1000_0000
	} state_t;

endpackage

/* hdl/lpcbv_ram.sv */
// Generic single-port RAM with registered read data.
module lpcbv_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* hdl/lpcbv_ctrl.sv */
// Controller state machine of the page cache.
module lpcbv_ctrl
	import lpcbv_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  dp_stat_t stat,
	output dp_cmd_t  ctl
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				ctl.sweep_init = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					ctl.capture = 1'b1;
					state_d     = ST_MATCH;
				end
			end
			ST_MATCH: begin
				ctl.match = 1'b1;
				state_d   = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_RESP;
				case (stat.cmd)
					CMD_CLEAR: begin
						ctl.clear_all = 1'b1;
					end
					CMD_LOOKUP: begin
						if (stat.go && stat.found) begin
							state_d = ST_CHECK;
						end
					end
					CMD_FILL: begin
						if (stat.go && stat.found) begin
							ctl.touch = 1'b1;
							state_d   = ST_WRITE;
						end else if (stat.go) begin
							ctl.alloc = 1'b1;
							state_d   = ST_SWEEP;
						end
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_CHECK: begin
				ctl.check = 1'b1;
				state_d   = ST_RESP;
			end
			ST_SWEEP: begin
				ctl.sweep_page = 1'b1;
				if (stat.sweep_last) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				ctl.write = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

endmodule

/* hdl/lpcbv_dp.sv */
// Datapath of the page cache: slot tags, recency ranks and byte lane memories.
module lpcbv_dp
	import lpcbv_pkg::*;
#(
	parameter int PAGE_BYTES   = 4096,
	parameter int NUM_SLOTS    = 16,
	parameter int ACCESS_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IN_W-1:0]  in_word,
	input  logic             cache_enable,
	input  logic [4:0]       max_pages,
	input  dp_cmd_t          ctl,
	output dp_stat_t         stat,
	output logic [OUT_W-1:0] out_word
);

	localparam int PW    = $clog2(PAGE_BYTES);
	localparam int TW    = 64 - PW;
	localparam int ROWS  = PAGE_BYTES / LANES;
	localparam int ROW_W = $clog2(ROWS);
	localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CW    = $clog2(NUM_SLOTS + 1);
	localparam int DEPTH = NUM_SLOTS * ROWS;
	localparam int AW    = $clog2(DEPTH);

	logic [1:0]        cmd_q;
	logic [63:0]       addr_q;
	logic [3:0]        size_q;
	logic [63:0]       fill_q;
	logic [TW-1:0]     tag_q [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] used_q;
	logic [SW-1:0]     rank_q [NUM_SLOTS];
	logic [CW-1:0]     count_q;
	logic              found_q;
	logic [SW-1:0]     idx_q;
	logic              hit_q;
	logic [63:0]       rd_q;
	logic [AW-1:0]     sweep_q;

	logic [PW-1:0]     off;
	logic [TW-1:0]     tag_in;
	logic              ok;
	logic              hit_any;
	logic [SW-1:0]     hit_idx;
	logic [CW-1:0]     lim;
	logic [CW-1:0]     lim_m1;
	logic              evict_on;
	logic [NUM_SLOTS-1:0] used_ev;
	logic [CW-1:0]     count_ev;
	logic [SW-1:0]     free_idx;
	logic [LANES-1:0]  active;
	logic [2:0]        lane_i [LANES];
	logic [AW-1:0]     ram_addr [LANES];
	logic [LANE_W-1:0] ram_wdata [LANES];
	logic [LANE_W-1:0] ram_rdata [LANES];
	logic [LANES-1:0]  ram_we;
	logic              all_valid;
	logic [63:0]       rd_comb;
	logic [SW+ROW_W-1:0] sweep_full;
	logic [CW+CNT_OUT_W-1:0] cnt_ext;
	logic              do_touch;

	assign off    = addr_q[PW-1:0];
	assign tag_in = addr_q[63:PW];
	assign ok     = (size_q != 4'd0) && (size_q <= ACCESS_BYTES) &&
		(({1'b0, off} + (PW+1)'(size_q)) <= (PW+1)'(PAGE_BYTES));

	assign stat.cmd   = cmd_q;
	assign stat.go    = cache_enable && ok;
	assign stat.found = found_q;
	assign stat.sweep_last = ctl.sweep_init ? (sweep_q == AW'(DEPTH - 1))
		: (&sweep_q[ROW_W-1:0]);

	always_comb begin
		hit_any = 1'b0;
		hit_idx = '0;
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (used_q[s] && (tag_q[s] == tag_in)) begin
				hit_any = 1'b1;
				hit_idx = SW'(s);
			end
		end
	end

	always_comb begin
		if (max_pages == 5'd0) begin
			lim = CW'(1);
		end else if (max_pages > NUM_SLOTS) begin
			lim = CW'(NUM_SLOTS);
		end else begin
			lim = CW'(max_pages);
		end
		lim_m1   = lim - CW'(1);
		evict_on = count_q >= lim;
		count_ev = evict_on ? lim_m1 : count_q;
		for (int s = 0; s < NUM_SLOTS; s++) begin
			used_ev[s] = used_q[s] && !(evict_on && (rank_q[s] >= lim_m1));
		end
		free_idx = '0;
		for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
			if (!used_ev[s]) begin
				free_idx = SW'(s);
			end
		end
	end

	assign sweep_full = {idx_q, sweep_q[ROW_W-1:0]};

	for (genvar j = 0; j < LANES; j++) begin : g_lane
		logic [PW:0]         pos;
		logic [SW+ROW_W-1:0] item_full;

		assign lane_i[j]  = 3'(j) - off[2:0];
		assign active[j]  = {1'b0, lane_i[j]} < size_q;
		assign pos        = {1'b0, off} + (PW+1)'(lane_i[j]);
		assign item_full  = {idx_q, pos[PW-1:3]};
		assign ram_addr[j] = ctl.sweep_init ? sweep_q
			: (ctl.sweep_page ? sweep_full[AW-1:0] : item_full[AW-1:0]);
		assign ram_we[j]  = ctl.sweep_init || ctl.sweep_page || (ctl.write && active[j]);
		assign ram_wdata[j] = (ctl.sweep_init || ctl.sweep_page) ? '0
			: {1'b1, fill_q[{lane_i[j], 3'b000} +: 8]};

		lpcbv_ram #(
			.WIDTH(LANE_W),
			.DEPTH(DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (ram_we[j]),
			.addr (ram_addr[j]),
			.wdata(ram_wdata[j]),
			.rdata(ram_rdata[j])
		);
	end

	always_comb begin
		all_valid = 1'b1;
		for (int j = 0; j < LANES; j++) begin
			if (active[j] && !ram_rdata[j][LANE_W-1]) begin
				all_valid = 1'b0;
			end
		end
		rd_comb = '0;
		for (int i = 0; i < LANES; i++) begin
			if ({1'b0, 3'(i)} < size_q) begin
				rd_comb[8*i +: 8] = ram_rdata[3'(i) + off[2:0]][7:0];
			end
		end
	end

	assign do_touch = ctl.touch || (ctl.check && all_valid);

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= in_word[1:0];
			addr_q <= in_word[65:2];
			size_q <= in_word[69:66];
			fill_q <= in_word[133:70];
		end
		if (ctl.alloc) begin
			tag_q[free_idx] <= tag_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			for (int s = 0; s < NUM_SLOTS; s++) begin
				rank_q[s] <= '0;
			end
			count_q <= '0;
			found_q <= 1'b0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			rd_q    <= '0;
			sweep_q <= '0;
		end else begin
			if (ctl.capture) begin
				hit_q <= 1'b0;
				rd_q  <= '0;
			end
			if (ctl.match) begin
				found_q <= hit_any;
				idx_q   <= hit_idx;
			end
			if (ctl.clear_all) begin
				used_q  <= '0;
				for (int s = 0; s < NUM_SLOTS; s++) begin
					rank_q[s] <= '0;
				end
				count_q <= '0;
			end
			if (do_touch) begin
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (used_q[s] && (rank_q[s] < rank_q[idx_q])) begin
						rank_q[s] <= rank_q[s] + SW'(1);
					end
				end
				rank_q[idx_q] <= '0;
			end
			if (ctl.check && all_valid) begin
				hit_q <= 1'b1;
				rd_q  <= rd_comb;
			end
			if (ctl.alloc) begin
				for (int s = 0; s < NUM_SLOTS; s++) begin
					used_q[s] <= used_ev[s];
					rank_q[s] <= used_ev[s] ? (rank_q[s] + SW'(1)) : '0;
				end
				used_q[free_idx] <= 1'b1;
				rank_q[free_idx] <= '0;
				count_q <= count_ev + CW'(1);
				idx_q   <= free_idx;
			end
			if (ctl.sweep_init || ctl.sweep_page) begin
				sweep_q <= stat.sweep_last ? '0 : (sweep_q + AW'(1));
			end
		end
	end

	assign cnt_ext  = (CW+CNT_OUT_W)'(count_q);
	assign out_word = {2'b00, cnt_ext[CNT_OUT_W-1:0], rd_q, hit_q};

endmodule

/* hdl/lru_page_cache_byte_valid_top.sv */
// Fully associative page cache with LRU replacement and per-byte valid bits.
//
// Input words arrive on s_tvalid/s_tready/s_tdata and carry a command (lookup, fill
// or clear), a byte address, a size of up to eight bytes and fill data. Each input
// word yields exactly one result word on m_tvalid/m_tready/m_tdata with the hit
// flag, the read bytes and the number of resident pages.
// The block works on one word at a time. A clear or a rejected request passes
// from acceptance through the match and decide states to the result. A lookup
// that finds its page adds a check state, a fill of a resident page adds a
// write state, and a fill that allocates a page adds a sweep that clears the
// valid bits of the new page one row a cycle, followed by a write state. After
// a result is taken, the block returns to idle before it accepts the next word.
// After reset the byte lane memories are cleared, one row a cycle; no word is
// accepted during that time, while configuration writes are taken. The cache
// then starts empty and enabled. While the receiver stalls, the result is held
// and no new word is accepted. PAGE_BYTES must be a power of two.
module lru_page_cache_byte_valid_top
	import lpcbv_pkg::*;
#(
	parameter int PAGE_BYTES   = 4096,
	parameter int NUM_SLOTS    = 16,
	parameter int ACCESS_BYTES = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	// cmd[1:0], address[65:2], size[69:66], fill_data[133:70], zero pad.
	input  logic [IN_W-1:0]  s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	// hit[0], read_data[64:1], resident_pages[69:65], zero pad.
	output logic [OUT_W-1:0] m_tdata,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	logic       enable_q;
	logic [4:0] max_pages_q;
	dp_cmd_t    ctl;
	dp_stat_t   stat;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= ENABLE_RST;
			max_pages_q <= MAX_PAGES_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_ENABLE: enable_q    <= pwdata[0];
				REG_MAX:    max_pages_q <= pwdata[4:0];
				default:    enable_q    <= enable_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_ENABLE: prdata = {31'd0, enable_q};
			REG_MAX:    prdata = {27'd0, max_pages_q};
			default:    prdata = '0;
		endcase
	end

	lpcbv_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.stat    (stat),
		.ctl     (ctl)
	);

	lpcbv_dp #(
		.PAGE_BYTES  (PAGE_BYTES),
		.NUM_SLOTS   (NUM_SLOTS),
		.ACCESS_BYTES(ACCESS_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_word     (s_tdata),
		.cache_enable(enable_q),
		.max_pages   (max_pages_q),
		.ctl         (ctl),
		.stat        (stat),
		.out_word    (m_tdata)
	);

endmodule

/* hdl/lpcbv_checker.sv */
// Port-level checker of the page cache and its binding to the top level.
`include "lru_page_cache_byte_valid_top_assert.svh"

module lpcbv_checker
	import lpcbv_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	`LPCBV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")
	`LPCBV_ASSERT(a_one_side, !(s_tready && m_tvalid), "input taken while a result waits")
	`LPCBV_ASSERT_NEXT(a_no_instant, s_tvalid && s_tready, !m_tvalid, "result shown in the cycle after acceptance")
	`LPCBV_ASSERT(a_miss_zero, !(m_tvalid && !m_tdata[0]) || (m_tdata[64:1] == 64'd0), "miss carries nonzero read data")

endmodule

bind lru_page_cache_byte_valid_top lpcbv_checker u_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
